// ===== design/mrc_pkg.sv =====
`default_nettype none
package mrc_pkg;

	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic [7:0]  MIN_FRAME    = 8'd5;
	localparam logic [7:0]  POS_MAX      = 8'd255;
	localparam int          HEADER_BYTES = 3;

	// one classified request: a finished word, a status, or both
	typedef struct packed {
		logic        has_word;
		logic [15:0] word;
		logic        has_status;
		logic        good;
		logic [7:0]  len;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage
`default_nettype wire

// ===== design/mrc_front.sv =====
`default_nettype none
module mrc_front (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic [7:0] frame_byte,
	input  wire                logic end_of_frame,
	input  wire                logic byte_valid,
	output logic               byte_ready,
	input  wire                mrc_pkg::fifo_stat_t stat,
	output logic               push,
	output mrc_pkg::rec_t      rec
);
	import mrc_pkg::*;

	localparam logic [7:0] DATA_POS = 8'(HEADER_BYTES + 2);

	logic [15:0] crc_q;
	logic [7:0]  held0_q, held1_q, pos_q, hi_q;
	logic        pend_q;

	logic        accept, released, data_byte, word_done;
	logic [15:0] crc_rel, crc_n;
	logic [7:0]  pos_inc;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	assign byte_ready = !stat.full;
	assign accept     = byte_valid && byte_ready;

	always_comb begin
		released  = pos_q >= 8'd2;
		data_byte = released && (pos_q >= DATA_POS);
		word_done = data_byte && pend_q;
		crc_rel   = crc_feed(crc_q, held0_q);
		crc_n     = released ? crc_rel : crc_q;
		pos_inc   = (pos_q == POS_MAX) ? pos_q : pos_q + 8'd1;

		rec.has_word   = word_done;
		rec.word       = {hi_q, held0_q};
		rec.has_status = end_of_frame;
		rec.good       = (pos_inc >= MIN_FRAME) && ({frame_byte, held1_q} == crc_n);
		rec.len        = pos_inc;
		push           = accept && (word_done || end_of_frame);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			held0_q <= '0;
			held1_q <= '0;
			pos_q   <= '0;
			hi_q    <= '0;
			pend_q  <= 1'b0;
		end else if (accept) begin
			if (end_of_frame) begin
				crc_q   <= CRC_INIT;
				held0_q <= '0;
				held1_q <= '0;
				pos_q   <= '0;
				hi_q    <= '0;
				pend_q  <= 1'b0;
			end else begin
				crc_q   <= crc_n;
				held0_q <= held1_q;
				held1_q <= frame_byte;
				pos_q   <= pos_inc;
				if (data_byte) begin
					if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						hi_q   <= held0_q;
						pend_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/mrc_fifo.sv =====
`default_nettype none
module mrc_fifo (
	input  wire                 logic clk,
	input  wire                 logic arst_n,
	input  wire                 logic push,
	input  wire                 mrc_pkg::rec_t wr_rec,
	input  wire                 logic pop,
	output mrc_pkg::rec_t       rd_rec,
	output mrc_pkg::fifo_stat_t stat
);
	import mrc_pkg::*;

	rec_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign stat.full  = count_q == 2'd2;
	assign stat.empty = count_q == 2'd0;
	assign rd_rec     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/mrc_back.sv =====
`default_nettype none
module mrc_back (
	input  wire                 logic clk,
	input  wire                 logic arst_n,
	input  wire                 mrc_pkg::rec_t rd_rec,
	input  wire                 mrc_pkg::fifo_stat_t stat,
	output logic                pop,
	output logic                result_valid,
	input  wire                 logic result_ready,
	output logic [15:0]         register_word,
	output logic                is_status,
	output logic                crc_good,
	output logic [7:0]          frame_length,
	output logic                last_result
);
	import mrc_pkg::*;

	logic valid_q, phase_q, load, emit_word;

	assign result_valid = valid_q;

	always_comb begin
		load      = (!valid_q || result_ready) && !stat.empty;
		emit_word = rd_rec.has_word && !phase_q;
		pop       = load && !(emit_word && rd_rec.has_status);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (result_ready)
				valid_q <= 1'b0;
			if (load)
				phase_q <= emit_word && rd_rec.has_status;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_word) begin
				register_word <= rd_rec.word;
				is_status     <= 1'b0;
				crc_good      <= 1'b0;
				frame_length  <= '0;
				last_result   <= !rd_rec.has_status;
			end else begin
				register_word <= '0;
				is_status     <= 1'b1;
				crc_good      <= rd_rec.good;
				frame_length  <= rd_rec.len;
				last_result   <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/modbus_rtu_response_checker.sv =====
// Modbus RTU response checker. Accepts one frame byte per cycle on byte_valid/byte_ready,
// with end_of_frame on the final byte, while the request queue is not full. The front end
// runs the CRC-16 (0xA001, seed 0xFFFF) one byte per cycle, holding the two newest bytes
// back until the frame ends, and pairs data bytes from offset 3 onward into big-endian
// register words. Results leave through a two-entry request queue and an output register,
// one result per cycle while result_ready is high: a byte gives at most one word, and the
// final byte a status (CRC match, length saturating at 255), so a final byte that also
// completes a word gives two results, word first; frames under 5 bytes report a bad CRC.
`default_nettype none
module modbus_rtu_response_checker (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic [7:0]  frame_byte,
	input  wire  logic        end_of_frame,
	input  wire  logic        byte_valid,
	output logic              byte_ready,
	output logic [15:0]       register_word,
	output logic              is_status,
	output logic              crc_good,
	output logic [7:0]        frame_length,
	output logic              last_result,
	output logic              result_valid,
	input  wire  logic        result_ready
);
	import mrc_pkg::*;

	rec_t       wr_rec, rd_rec;
	fifo_stat_t stat;
	logic       push, pop;

	mrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_byte (frame_byte),
		.end_of_frame(end_of_frame),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.stat       (stat),
		.push       (push),
		.rec        (wr_rec)
	);

	mrc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.rd_rec (rd_rec),
		.stat   (stat)
	);

	mrc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_rec       (rd_rec),
		.stat         (stat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.register_word(register_word),
		.is_status    (is_status),
		.crc_good     (crc_good),
		.frame_length (frame_length),
		.last_result  (last_result)
	);

endmodule
`default_nettype wire

// ===== bench/tb_modbus_rtu_response_checker.sv =====
`timescale 1ns / 100ps
module tb_modbus_rtu_response_checker;
	import mrc_pkg::*;

	localparam int RANDOM_BYTES  = 1250;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int DIRECTED_ROWS = 25;

	typedef struct packed {
		logic [15:0] register_word;
		logic        is_status;
		logic        crc_good;
		logic [7:0]  frame_length;
		logic        last_result;
	} response_t;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_CRC_LO, ROW_CRC_HI, ROW_SHORT} row_kind_e;

	typedef struct packed {
		logic [7:0] value;
		logic       eof;
		row_kind_e  kind;
		logic [7:0] typed_len;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic [7:0]  frame_byte;
	logic        end_of_frame;
	logic        byte_valid;
	logic        byte_ready;
	logic [15:0] register_word;
	logic        is_status;
	logic        crc_good;
	logic [7:0]  frame_length;
	logic        last_result;
	logic        result_valid;
	logic        result_ready;

	modbus_rtu_response_checker u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_byte   (frame_byte),
		.end_of_frame (end_of_frame),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.register_word(register_word),
		.is_status    (is_status),
		.crc_good     (crc_good),
		.frame_length (frame_length),
		.last_result  (last_result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

	// short frames, a good frame with a word on its final byte, an odd data byte
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{8'hFF, 1'b1, ROW_SHORT,   8'd1},
		'{8'h00, 1'b0, ROW_PREDICT, 8'd0},
		'{8'hFF, 1'b1, ROW_SHORT,   8'd2},
		'{8'h55, 1'b0, ROW_PREDICT, 8'd0},
		'{8'hAA, 1'b0, ROW_PREDICT, 8'd0},
		'{8'h0F, 1'b1, ROW_SHORT,   8'd3},
		'{8'h01, 1'b0, ROW_PREDICT, 8'd0},
		'{8'h03, 1'b0, ROW_PREDICT, 8'd0},
		'{8'h00, 1'b0, ROW_PREDICT, 8'd0},
		'{8'hF0, 1'b1, ROW_SHORT,   8'd4},
		'{8'h01, 1'b0, ROW_PREDICT, 8'd0},
		'{8'h03, 1'b0, ROW_PREDICT, 8'd0},
		'{8'h04, 1'b0, ROW_PREDICT, 8'd0},
		'{8'h00, 1'b0, ROW_PREDICT, 8'd0},
		'{8'h00, 1'b0, ROW_PREDICT, 8'd0},
		'{8'hFF, 1'b0, ROW_PREDICT, 8'd0},
		'{8'hFF, 1'b0, ROW_PREDICT, 8'd0},
		'{8'h00, 1'b0, ROW_CRC_LO,  8'd0},
		'{8'h00, 1'b1, ROW_CRC_HI,  8'd0},
		'{8'h01, 1'b0, ROW_PREDICT, 8'd0},
		'{8'h03, 1'b0, ROW_PREDICT, 8'd0},
		'{8'h01, 1'b0, ROW_PREDICT, 8'd0},
		'{8'hAB, 1'b0, ROW_PREDICT, 8'd0},
		'{8'h00, 1'b0, ROW_CRC_LO,  8'd0},
		'{8'h00, 1'b1, ROW_CRC_HI,  8'd0}
	};

	response_t   expected_responses [$];
	response_t   step_results [2];
	int          step_count;

	logic [15:0] frame_crc;
	logic [7:0]  held_bytes [2];
	logic [7:0]  byte_pos;
	logic [7:0]  word_high;
	logic        word_half;

	int          cycle_count = 0;
	int          fail_count  = 0;
	int          bytes_sent  = 0;
	int          frames_sent = 0;
	int          words_seen  = 0;
	int          status_seen = 0;
	int          good_seen   = 0;
	int          tx_run_left = 0;
	bit          tx_busy;
	int          rx_run_left = 0;
	bit          rx_busy;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] value);
		logic [15:0] c;
		c = crc ^ {8'h00, value};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic int draw_wait(inout int run_left, inout bit stretch_busy);
		if (run_left == 0) begin
			stretch_busy = ($urandom_range(0, 2) != 0);
			run_left = $urandom_range(8, 48);
		end
		run_left--;
		return stretch_busy ? int'($urandom_range(0, 9)) : 0;
	endfunction

	task automatic clear_predictor();
		frame_crc     = CRC_INIT;
		held_bytes[0] = 8'h00;
		held_bytes[1] = 8'h00;
		byte_pos      = 8'h00;
		word_high     = 8'h00;
		word_half     = 1'b0;
	endtask

	task automatic predict_response(input logic [7:0] value, input logic eof);
		logic [7:0] released;
		step_count = 0;
		if (byte_pos >= 8'd2) begin
			released  = held_bytes[0];
			frame_crc = crc16_byte(frame_crc, released);
			if (int'(byte_pos) - 2 >= HEADER_BYTES) begin
				if (word_half) begin
					step_results[step_count] = '{{word_high, released}, 1'b0, 1'b0, 8'h00, 1'b0};
					step_count++;
					word_half = 1'b0;
				end else begin
					word_high = released;
					word_half = 1'b1;
				end
			end
		end
		held_bytes[0] = held_bytes[1];
		held_bytes[1] = value;
		if (byte_pos != POS_MAX)
			byte_pos = byte_pos + 8'd1;
		if (eof) begin
			step_results[step_count] = '{16'h0000, 1'b1,
				(byte_pos >= MIN_FRAME) && ({held_bytes[1], held_bytes[0]} == frame_crc),
				byte_pos, 1'b0};
			step_count++;
			clear_predictor();
		end
		if (step_count > 0)
			step_results[step_count - 1].last_result = 1'b1;
	endtask

	task automatic send_request(input logic [7:0] value, input logic eof,
			input logic typed, input logic [7:0] typed_len);
		int gap;
		gap = draw_wait(tx_run_left, tx_busy);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_byte   <= value;
		end_of_frame <= eof;
		byte_valid   <= 1'b1;
		do @(posedge clk); while (!byte_ready);
		bytes_sent++;
		if (eof)
			frames_sent++;
		predict_response(value, eof);
		if (typed)
			expected_responses.push_back('{16'h0000, 1'b1, 1'b0, typed_len, 1'b1});
		else
			for (int i = 0; i < step_count; i++)
				expected_responses.push_back(step_results[i]);
	endtask

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_modbus_rtu_response_checker NOT OK");
		$finish;
	end

	initial begin
		response_t exp_r;
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		result_ready <= 1'b1;
		forever begin
			int stall;
			do @(posedge clk); while (!result_valid);
			if (is_status) begin
				status_seen++;
				if (crc_good)
					good_seen++;
			end else begin
				words_seen++;
			end
			if (expected_responses.size() == 0) begin
				$error("result with no request pending");
				fail_count++;
			end else begin
				exp_r = expected_responses.pop_front();
				if (register_word !== exp_r.register_word) begin
					$error("register_word: expected %h, got %h", exp_r.register_word, register_word);
					fail_count++;
				end
				if (is_status !== exp_r.is_status) begin
					$error("is_status: expected %b, got %b", exp_r.is_status, is_status);
					fail_count++;
				end
				if (crc_good !== exp_r.crc_good) begin
					$error("crc_good: expected %b, got %b", exp_r.crc_good, crc_good);
					fail_count++;
				end
				if (frame_length !== exp_r.frame_length) begin
					$error("frame_length: expected %0d, got %0d", exp_r.frame_length,
						frame_length);
					fail_count++;
				end
				if (last_result !== exp_r.last_result) begin
					$error("last_result: expected %b, got %b", exp_r.last_result, last_result);
					fail_count++;
				end
			end
			stall = draw_wait(rx_run_left, rx_busy);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [15:0] tx_crc;
		logic [7:0]  value;
		logic [7:0]  frame_q [$];
		int          random_start;
		int          body_len;
		int          pick;
		int          frame_idx;
		int          flip_at;

		arst_n       <= 1'b0;
		byte_valid   <= 1'b0;
		frame_byte   <= 8'h00;
		end_of_frame <= 1'b0;
		clear_predictor();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		tx_crc = CRC_INIT;
		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_CRC_LO: value = tx_crc[7:0];
				ROW_CRC_HI: value = tx_crc[15:8];
				default: begin
					value  = directed_rows[i].value;
					tx_crc = crc16_byte(tx_crc, value);
				end
			endcase
			send_request(value, directed_rows[i].eof, directed_rows[i].kind == ROW_SHORT,
				directed_rows[i].typed_len);
			if (directed_rows[i].eof)
				tx_crc = CRC_INIT;
		end

		random_start = bytes_sent;
		frame_idx    = 0;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			frame_q.delete();
			pick = $urandom_range(0, 99);
			if (frame_idx == 10)
				body_len = 253;
			else if (frame_idx == 40)
				body_len = 262;
			else
				body_len = $urandom_range(3, 18);
			if (pick < 85 || frame_idx == 10 || frame_idx == 40) begin
				tx_crc = CRC_INIT;
				repeat (body_len) begin
					value = 8'($urandom_range(0, 255));
					frame_q.push_back(value);
					tx_crc = crc16_byte(tx_crc, value);
				end
				frame_q.push_back(tx_crc[7:0]);
				frame_q.push_back(tx_crc[15:8]);
				// corrupt one bit
				if (pick >= 70 && pick < 85) begin
					flip_at = $urandom_range(0, frame_q.size() - 1);
					frame_q[flip_at] = frame_q[flip_at] ^ (8'h01 << $urandom_range(0, 7));
				end
			end else begin
				repeat ($urandom_range(1, 12))
					frame_q.push_back(8'($urandom_range(0, 255)));
			end
			if (frame_idx == 25) begin
				byte_valid <= 1'b0;
				do @(posedge clk); while (expected_responses.size() != 0);
			end
			foreach (frame_q[i])
				send_request(frame_q[i], i == frame_q.size() - 1, 1'b0, 8'h00);
			frame_idx++;
		end

		byte_valid <= 1'b0;
		do @(posedge clk); while (expected_responses.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d frames, %0d bytes sent; %0d register words and %0d status results checked",
			frames_sent, bytes_sent, words_seen, status_seen);
		$display("%0d frames reported a good CRC; %0d mismatches", good_seen, fail_count);
		if (fail_count == 0)
			$display("tb_modbus_rtu_response_checker OK");
		else
			$display("tb_modbus_rtu_response_checker NOT OK");
		$finish;
	end

endmodule
